FILE: design/ntms_pkg.sv
// Shared types, codes and widths for the nearest triangle match search.
package ntms_pkg;

  localparam int MAX_FACES_DEF  = 4096;
  localparam int COORD_BITS_DEF = 24;

  localparam int IN_COORD_W = 24;
  localparam int THR_W      = 51;
  localparam int SCORE_W    = 52;
  localparam int IDX_W      = 12;
  localparam int STATUS_W   = 3;
  localparam int REQ_W      = 2;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(167772);

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_UNUSED = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_MATCH   = 3'd0,
    ST_NOMATCH = 3'd1,
    ST_LOADED  = 3'd2,
    ST_FULL    = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  // Control that travels with each candidate along the cell chain.
  typedef struct packed {
    logic valid;
    logic last;
    logic reject;
  } chain_ctrl_t;

endpackage

FILE: design/ntms_cell.sv
// One vertex cell: squared distance of one vertex, threshold check, running sum.
module ntms_cell #(
  parameter int COORD_BITS = ntms_pkg::COORD_BITS_DEF,
  parameter int SLOT_W     = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [ntms_pkg::THR_W-1:0]     thr,
  input  logic                           q_load,
  input  logic [COORD_BITS-1:0]          q_x,
  input  logic [COORD_BITS-1:0]          q_y,
  input  logic [COORD_BITS-1:0]          q_z,
  input  ntms_pkg::chain_ctrl_t          in_ctrl,
  input  logic [SLOT_W-1:0]              in_slot,
  input  logic [ntms_pkg::SCORE_W-1:0]   in_total,
  input  logic [9*COORD_BITS-1:0]        in_word,
  output ntms_pkg::chain_ctrl_t          out_ctrl,
  output logic [SLOT_W-1:0]              out_slot,
  output logic [ntms_pkg::SCORE_W-1:0]   out_total,
  output logic [9*COORD_BITS-1:0]        out_word
);
  import ntms_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int SQ_W  = 2 * CB;
  localparam int SUM_W = 2 * CB + 2;
  localparam int WW    = 9 * CB;

  logic [CB-1:0]      q_r [3];
  logic [SQ_W-1:0]    sq_nxt [3];
  logic [SQ_W-1:0]    sq_a_r [3];
  chain_ctrl_t        ctrl_a_r;
  logic [SLOT_W-1:0]  slot_a_r;
  logic [SCORE_W-1:0] total_a_r;
  logic [WW-1:0]      word_a_r;
  chain_ctrl_t        ctrl_b_r, ctrl_b_nxt;
  logic [SLOT_W-1:0]  slot_b_r;
  logic [SCORE_W-1:0] total_b_r;
  logic [WW-1:0]      word_b_r;
  logic [SUM_W-1:0]   sum;
  logic               over;

  always_ff @(posedge clk) begin
    if (q_load) begin
      q_r[0] <= q_x;
      q_r[1] <= q_y;
      q_r[2] <= q_z;
    end
  end

  // Per-axis absolute difference and square; this cell uses the lowest vertex of the word.
  always_comb begin
    logic [CB-1:0] rc;
    logic [CB:0]   d;
    logic [CB:0]   ad;
    for (int a = 0; a < 3; a++) begin
      rc = in_word[a*CB +: CB];
      d  = {q_r[a][CB-1], q_r[a]} - {rc[CB-1], rc};
      ad = d[CB] ? (~d + 1'b1) : d;
      sq_nxt[a] = ad[CB-1:0] * ad[CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_a_r <= '0;
    end else begin
      ctrl_a_r <= in_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    slot_a_r  <= in_slot;
    total_a_r <= in_total;
    word_a_r  <= {{(3*CB){1'b0}}, in_word[WW-1:3*CB]};
    for (int a = 0; a < 3; a++) begin
      sq_a_r[a] <= sq_nxt[a];
    end
  end

  assign sum  = SUM_W'(sq_a_r[0]) + SUM_W'(sq_a_r[1]) + SUM_W'(sq_a_r[2]);
  assign over = THR_W'(sum) > thr;

  always_comb begin
    ctrl_b_nxt        = ctrl_a_r;
    ctrl_b_nxt.reject = ctrl_a_r.reject | over;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_b_r <= '0;
    end else begin
      ctrl_b_r <= ctrl_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_b_r  <= slot_a_r;
    total_b_r <= total_a_r + SCORE_W'(sum);
    word_b_r  <= word_a_r;
  end

  assign out_ctrl  = ctrl_b_r;
  assign out_slot  = slot_b_r;
  assign out_total = total_b_r;
  assign out_word  = word_b_r;

endmodule

FILE: design/nearest_triangle_match_search_top.sv
// Top level of the nearest triangle match search: triangle table, scan control, cell chain.
//
//   channel | ports                                          | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid, in_ready, in_req_type, in_v*         | to block
//   out     | out_valid, out_ready, out_status, ...          | from block
//   cfg     | cfg_valid, cfg_ready, cfg_dist_threshold_sq    | to block
//
// Load, clear and unused requests write the result register at the transfer
// edge. A query reads one stored triangle per cycle from the table memory, and
// its result passes the read register, two stages in each of three vertex cells
// and then the result register; an empty table answers at the transfer edge.
// Reset empties the table and sets the threshold to its default. A stalled
// result holds the input off until it is taken or is taken in the same cycle;
// configuration is always ready.
module nearest_triangle_match_search_top #(
  parameter int MAX_FACES  = ntms_pkg::MAX_FACES_DEF,
  parameter int COORD_BITS = ntms_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ntms_pkg::REQ_W-1:0]        in_req_type,
  input  logic signed [ntms_pkg::IN_COORD_W-1:0] in_v0_x,
  input  logic signed [ntms_pkg::IN_COORD_W-1:0] in_v0_y,
  input  logic signed [ntms_pkg::IN_COORD_W-1:0] in_v0_z,
  input  logic signed [ntms_pkg::IN_COORD_W-1:0] in_v1_x,
  input  logic signed [ntms_pkg::IN_COORD_W-1:0] in_v1_y,
  input  logic signed [ntms_pkg::IN_COORD_W-1:0] in_v1_z,
  input  logic signed [ntms_pkg::IN_COORD_W-1:0] in_v2_x,
  input  logic signed [ntms_pkg::IN_COORD_W-1:0] in_v2_y,
  input  logic signed [ntms_pkg::IN_COORD_W-1:0] in_v2_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ntms_pkg::STATUS_W-1:0]     out_status,
  output logic [ntms_pkg::IDX_W-1:0]        out_face_index,
  output logic [ntms_pkg::SCORE_W-1:0]      out_fit_score,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ntms_pkg::THR_W-1:0]        cfg_dist_threshold_sq
);
  import ntms_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int WW = 9 * CB;
  localparam int AW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int CW = $clog2(MAX_FACES + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [THR_W-1:0]   thr_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic [AW-1:0]      scan_idx_r, scan_idx_nxt;
  logic [SCORE_W-1:0] best_score_r, best_score_nxt;
  logic [AW-1:0]      best_slot_r, best_slot_nxt;
  logic               found_r, found_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [IDX_W-1:0]   out_index_r, out_index_nxt;
  logic [SCORE_W-1:0] out_score_r, out_score_nxt;

  logic [WW-1:0]      mem [MAX_FACES];
  logic [WW-1:0]      rdata_r;
  chain_ctrl_t        rd_ctrl_r, rd_ctrl_nxt;
  logic [AW-1:0]      rd_slot_r;

  logic [CB-1:0]      qc [9];
  logic [WW-1:0]      in_word;
  logic               in_xfer, load_we, rd_en, is_last, cand;
  logic [SCORE_W-1:0] cur_score;
  logic [AW-1:0]      cur_slot;
  logic               cur_found;

  chain_ctrl_t        ctrl_c  [4];
  logic [AW-1:0]      slot_c  [4];
  logic [SCORE_W-1:0] total_c [4];
  logic [WW-1:0]      word_c  [4];

  // Each coordinate is its low COORD_BITS bits; the cells sign-extend them.
  assign qc[0] = in_v0_x[CB-1:0];
  assign qc[1] = in_v0_y[CB-1:0];
  assign qc[2] = in_v0_z[CB-1:0];
  assign qc[3] = in_v1_x[CB-1:0];
  assign qc[4] = in_v1_y[CB-1:0];
  assign qc[5] = in_v1_z[CB-1:0];
  assign qc[6] = in_v2_x[CB-1:0];
  assign qc[7] = in_v2_y[CB-1:0];
  assign qc[8] = in_v2_z[CB-1:0];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      in_word[k*CB +: CB] = qc[k];
    end
  end

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // The configuration register may be written at any time the block is idle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_dist_threshold_sq;
    end
  end

  // Triangle table: one write port for loads, one registered read for the scan.
  assign load_we = in_xfer && (req_t'(in_req_type) == REQ_LOAD) &&
                   (count_r < CW'(MAX_FACES));
  assign rd_en   = (state_r == S_SCAN);
  assign is_last = (CW'(scan_idx_r) + CW'(1)) == count_r;

  always_ff @(posedge clk) begin
    if (load_we) begin
      mem[count_r[AW-1:0]] <= in_word;
    end
    if (rd_en) begin
      rdata_r <= mem[scan_idx_r];
    end
    rd_slot_r <= scan_idx_r;
  end

  always_comb begin
    rd_ctrl_nxt        = '0;
    rd_ctrl_nxt.valid  = rd_en;
    rd_ctrl_nxt.last   = rd_en && is_last;
  end

  // Chain head: a fresh candidate enters with a zero running sum.
  assign ctrl_c[0]  = rd_ctrl_r;
  assign slot_c[0]  = rd_slot_r;
  assign total_c[0] = '0;
  assign word_c[0]  = rdata_r;

  // Three identical cells, one per vertex. Each holds its query vertex and hands
  // the candidate, its reject flag and running sum to the next cell.
  for (genvar g = 0; g < 3; g++) begin : g_cell
    ntms_cell #(
      .COORD_BITS(COORD_BITS),
      .SLOT_W    (AW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .thr      (thr_r),
      .q_load   (in_xfer && (req_t'(in_req_type) == REQ_QUERY)),
      .q_x      (qc[3*g]),
      .q_y      (qc[3*g+1]),
      .q_z      (qc[3*g+2]),
      .in_ctrl  (ctrl_c[g]),
      .in_slot  (slot_c[g]),
      .in_total (total_c[g]),
      .in_word  (word_c[g]),
      .out_ctrl (ctrl_c[g+1]),
      .out_slot (slot_c[g+1]),
      .out_total(total_c[g+1]),
      .out_word (word_c[g+1])
    );
  end

  // Running best: candidates leave the chain in slot order, so a strict less-than
  // keeps the first slot on ties.
  assign cand      = ctrl_c[3].valid && !ctrl_c[3].reject && (total_c[3] < best_score_r);
  assign cur_score = cand ? total_c[3] : best_score_r;
  assign cur_slot  = cand ? slot_c[3] : best_slot_r;
  assign cur_found = found_r || cand;

  always_comb begin
    logic [AW+IDX_W-1:0] count_ext;
    logic [AW+IDX_W-1:0] slot_ext;
    count_ext      = {{IDX_W{1'b0}}, count_r[AW-1:0]};
    slot_ext       = {{IDX_W{1'b0}}, cur_slot};
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    best_score_nxt = cur_score;
    best_slot_nxt  = cur_slot;
    found_nxt      = cur_found;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_score_nxt  = out_score_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NOMATCH;
          out_index_nxt  = '0;
          out_score_nxt  = '0;
          case (req_t'(in_req_type))
            REQ_LOAD: begin
              if (load_we) begin
                out_status_nxt = ST_LOADED;
                out_index_nxt  = count_ext[IDX_W-1:0];
                count_nxt      = count_r + CW'(1);
              end else begin
                out_status_nxt = ST_FULL;
              end
            end
            REQ_QUERY: begin
              best_score_nxt = '1;
              best_slot_nxt  = '0;
              found_nxt      = 1'b0;
              scan_idx_nxt   = '0;
              if (count_r != '0) begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_SCAN;
              end
            end
            REQ_CLEAR: begin
              count_nxt      = '0;
              out_status_nxt = ST_CLEARED;
            end
            default: begin
              out_status_nxt = ST_NOMATCH;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (is_last) begin
          state_nxt = S_DRAIN;
        end else begin
          scan_idx_nxt = scan_idx_r + AW'(1);
        end
      end
      S_DRAIN: begin
        if (ctrl_c[3].valid && ctrl_c[3].last) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (cur_found) begin
            out_status_nxt = ST_MATCH;
            out_index_nxt  = slot_ext[IDX_W-1:0];
            out_score_nxt  = cur_score;
          end else begin
            out_status_nxt = ST_NOMATCH;
            out_index_nxt  = '0;
            out_score_nxt  = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      scan_idx_r   <= '0;
      best_score_r <= '1;
      best_slot_r  <= '0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      rd_ctrl_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      scan_idx_r   <= scan_idx_nxt;
      best_score_r <= best_score_nxt;
      best_slot_r  <= best_slot_nxt;
      found_r      <= found_nxt;
      out_valid_r  <= out_valid_nxt;
      rd_ctrl_r    <= rd_ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_score_r  <= out_score_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_face_index = out_index_r;
  assign out_fit_score  = out_score_r;

endmodule

FILE: tb/sv/nearest_triangle_match_search_top_tb.sv
// Self-checking testbench for the nearest triangle match search top level.
module nearest_triangle_match_search_top_tb;
  import ntms_pkg::*;

  localparam int TABLE_DEPTH = MAX_FACES_DEF;
  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [SCORE_W-1:0] SCORE_ALL_ONES = '1;
  localparam logic [THR_W-1:0] THR_MAX = '1;

  // One request as it travels on the input channel.
  typedef struct {
    req_t                          req;
    logic signed [IN_COORD_W-1:0]  c [9];
  } tri_req_t;

  // One answer as it travels on the result channel.
  typedef struct {
    status_t             st;
    logic [IDX_W-1:0]    idx;
    logic [SCORE_W-1:0]  score;
  } answer_t;

  // A directed row: the request and, where it is plain, the answer.
  typedef struct {
    tri_req_t  rq;
    logic      typed;
    answer_t   ans;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [REQ_W-1:0] in_req_type;
  logic signed [IN_COORD_W-1:0] in_v0_x, in_v0_y, in_v0_z;
  logic signed [IN_COORD_W-1:0] in_v1_x, in_v1_y, in_v1_z;
  logic signed [IN_COORD_W-1:0] in_v2_x, in_v2_y, in_v2_z;
  logic out_valid;
  logic out_ready;
  logic [STATUS_W-1:0] out_status;
  logic [IDX_W-1:0] out_face_index;
  logic [SCORE_W-1:0] out_fit_score;
  logic cfg_valid;
  logic cfg_ready;
  logic [THR_W-1:0] cfg_dist_threshold_sq;

  nearest_triangle_match_search_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_v0_x(in_v0_x), .in_v0_y(in_v0_y), .in_v0_z(in_v0_z),
    .in_v1_x(in_v1_x), .in_v1_y(in_v1_y), .in_v1_z(in_v1_z),
    .in_v2_x(in_v2_x), .in_v2_y(in_v2_y), .in_v2_z(in_v2_z),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_face_index(out_face_index), .out_fit_score(out_fit_score),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_dist_threshold_sq(cfg_dist_threshold_sq)
  );

  // Predictor state: our own copy of the triangle table and threshold.
  logic signed [IN_COORD_W-1:0] ref_faces [TABLE_DEPTH][9];
  int unsigned      ref_count;
  logic [THR_W-1:0] ref_thresh;

  answer_t pending_answers[$];
  int      error_count;
  int      cycle_count;

  // Idle percentages and a long receiver hold-off, set by the main sequence.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned recv_holdoff;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Squared distance between two signed coordinates, exact in 64 bits.
  function automatic logic [63:0] coord_sq(logic signed [IN_COORD_W-1:0] a,
                                           logic signed [IN_COORD_W-1:0] b);
    logic signed [63:0] d;
    d = 64'(a) - 64'(b);
    if (d < 0) d = -d;
    return d * d;
  endfunction

  // Runs one request through the predictor, updating the table on loads and clears.
  function automatic answer_t predict_answer(tri_req_t rq);
    answer_t a;
    logic [63:0] best, total, vsq;
    logic found, pass;
    a.st = ST_NOMATCH;
    a.idx = '0;
    a.score = '0;
    case (rq.req)
      REQ_LOAD: begin
        if (ref_count >= TABLE_DEPTH) begin
          a.st = ST_FULL;
        end else begin
          for (int k = 0; k < 9; k++) ref_faces[ref_count][k] = rq.c[k];
          a.st = ST_LOADED;
          a.idx = IDX_W'(ref_count);
          ref_count++;
        end
      end
      REQ_QUERY: begin
        best = 64'(SCORE_ALL_ONES);
        found = 1'b0;
        for (int n = 0; n < ref_count; n++) begin
          total = 0;
          pass = 1'b1;
          for (int v = 0; v < 3; v++) begin
            vsq = coord_sq(rq.c[v*3], ref_faces[n][v*3]) +
                  coord_sq(rq.c[v*3+1], ref_faces[n][v*3+1]) +
                  coord_sq(rq.c[v*3+2], ref_faces[n][v*3+2]);
            if (vsq > 64'(ref_thresh)) pass = 1'b0;
            total += vsq;
          end
          if (pass && total < best) begin
            best = total;
            a.idx = IDX_W'(n);
            found = 1'b1;
          end
        end
        if (found) begin
          a.st = ST_MATCH;
          a.score = best[SCORE_W-1:0];
        end else begin
          a.idx = '0;
        end
      end
      REQ_CLEAR: begin
        ref_count = 0;
        a.st = ST_CLEARED;
      end
      default: ;
    endcase
    return a;
  endfunction

  // Sends one request, waiting out the random idle gap first. Valid stays high
  // after the transfer until the next request or an idle cycle replaces it.
  task automatic send_request(tri_req_t rq);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rq.req;
    in_v0_x <= rq.c[0]; in_v0_y <= rq.c[1]; in_v0_z <= rq.c[2];
    in_v1_x <= rq.c[3]; in_v1_y <= rq.c[4]; in_v1_z <= rq.c[5];
    in_v2_x <= rq.c[6]; in_v2_y <= rq.c[7]; in_v2_z <= rq.c[8];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // The transfer happened at this edge; the expectation is queued now.
    pending_answers = {pending_answers, predict_answer(rq)};
  endtask

  // Sends one directed row, also checking the typed-in answer against the predictor.
  task automatic send_row(dir_row_t row);
    answer_t p;
    send_request(row.rq);
    if (row.typed) begin
      p = pending_answers[$];
      if (p.st != row.ans.st || p.idx != row.ans.idx || p.score != row.ans.score) begin
        $display("%0t: directed row differs: expected %0d/%0d/%0d actual %0d/%0d/%0d",
                 $time, row.ans.st, row.ans.idx, row.ans.score, p.st, p.idx, p.score);
        error_count++;
      end
    end
  endtask

  // Waits until every queued answer has arrived, then lets the pipeline drain.
  task automatic drain_answers();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 20) @(posedge clk);
  endtask

  // Writes the threshold register while the block is idle.
  task automatic write_threshold(logic [THR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_dist_threshold_sq <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ref_thresh = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [IN_COORD_W-1:0] rand_coord();
    return IN_COORD_W'($urandom());
  endfunction

  function automatic tri_req_t make_req(req_t r, logic signed [IN_COORD_W-1:0] fill);
    tri_req_t t;
    t.req = r;
    for (int k = 0; k < 9; k++) t.c[k] = fill;
    return t;
  endfunction

  // A query near a stored triangle: small random offsets so matches are common.
  function automatic tri_req_t near_query(int unsigned spread);
    tri_req_t t;
    int unsigned n;
    t = make_req(REQ_QUERY, '0);
    if (ref_count == 0) begin
      for (int k = 0; k < 9; k++) t.c[k] = rand_coord();
    end else begin
      n = $urandom_range(ref_count - 1, 0);
      for (int k = 0; k < 9; k++)
        t.c[k] = ref_faces[n][k] + IN_COORD_W'($signed($urandom_range(2*spread, 0)) -
                                                $signed(spread));
    end
    return t;
  endfunction

  // Mostly loads of clustered triangles and queries near them; some noise.
  function automatic tri_req_t random_req();
    tri_req_t t;
    int unsigned pick;
    logic signed [IN_COORD_W-1:0] base;
    pick = $urandom_range(99, 0);
    if (pick < 35) begin
      t = make_req(REQ_LOAD, '0);
      base = $urandom_range(3, 0) == 0 ? rand_coord() : IN_COORD_W'($urandom_range(4000, 0));
      for (int k = 0; k < 9; k++) t.c[k] = base + IN_COORD_W'($urandom_range(600, 0));
    end else if (pick < 80) begin
      t = near_query($urandom_range(1, 0) ? 200 : 2000);
    end else if (pick < 90) begin
      t = make_req(REQ_QUERY, '0);
      for (int k = 0; k < 9; k++) t.c[k] = rand_coord();
    end else if (pick < 95) begin
      t = make_req(REQ_CLEAR, rand_coord());
    end else begin
      t = make_req(REQ_UNUSED, rand_coord());
    end
    return t;
  endfunction

  // Result side: random stalls plus one long hold-off, counted here in cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (recv_holdoff != 0) begin
      recv_holdoff <= recv_holdoff - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Each transfer on the result channel is compared with the oldest expectation.
  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result: status %0d index %0d score %0d",
                 $time, out_status, out_face_index, out_fit_score);
        error_count++;
      end else begin
        e = pending_answers.pop_front();
        if (out_status !== e.st) begin
          $display("%0t: status mismatch: expected %0d actual %0d", $time, e.st, out_status);
          error_count++;
        end
        if (out_face_index !== e.idx) begin
          $display("%0t: face_index mismatch: expected %0d actual %0d",
                   $time, e.idx, out_face_index);
          error_count++;
        end
        if (out_fit_score !== e.score) begin
          $display("%0t: fit_score mismatch: expected %0d actual %0d",
                   $time, e.score, out_fit_score);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  dir_row_t dir_rows[$];

  function automatic dir_row_t row(tri_req_t rq, logic typed, status_t st,
                                   int unsigned idx, logic [SCORE_W-1:0] score);
    dir_row_t r;
    r.rq = rq;
    r.typed = typed;
    r.ans.st = st;
    r.ans.idx = IDX_W'(idx);
    r.ans.score = score;
    return r;
  endfunction

  initial begin
    tri_req_t t;
    int unsigned phase_items;
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 12;
    recv_idle_pct = 73;
    recv_holdoff = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_LOAD;
    {in_v0_x, in_v0_y, in_v0_z, in_v1_x, in_v1_y, in_v1_z, in_v2_x, in_v2_y, in_v2_z} = '0;
    cfg_valid = 1'b0;
    cfg_dist_threshold_sq = '0;
    ref_count = 0;
    ref_thresh = THR_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: empty-table query, the extremes of the coordinates,
    // a perfect match, ties, the threshold edge, the unused type and clears.
    dir_rows = {dir_rows, row(make_req(REQ_QUERY, '0), 1, ST_NOMATCH, 0, 0)};
    dir_rows = {dir_rows, row(make_req(REQ_LOAD, 24'sh7FFFFF), 1, ST_LOADED, 0, 0)};
    dir_rows = {dir_rows, row(make_req(REQ_LOAD, -24'sh800000), 1, ST_LOADED, 1, 0)};
    dir_rows = {dir_rows, row(make_req(REQ_LOAD, 24'sd0), 1, ST_LOADED, 2, 0)};
    dir_rows = {dir_rows, row(make_req(REQ_LOAD, 24'sd0), 1, ST_LOADED, 3, 0)};
    dir_rows = {dir_rows, row(make_req(REQ_QUERY, 24'sd0), 1, ST_MATCH, 2, 0)};
    dir_rows = {dir_rows, row(make_req(REQ_QUERY, 24'sh7FFFFF), 1, ST_MATCH, 0, 0)};
    dir_rows = {dir_rows, row(make_req(REQ_QUERY, -24'sh800000), 1, ST_MATCH, 1, 0)};
    // Every axis off by 236: 3*236^2 = 167088 per vertex, just under 167772.
    dir_rows = {dir_rows, row(make_req(REQ_QUERY, 24'sd236), 0, ST_MATCH, 2, 0)};
    // 237 in all three axes: 3*237^2 = 168507 per vertex, over the limit.
    dir_rows = {dir_rows, row(make_req(REQ_QUERY, 24'sd237), 1, ST_NOMATCH, 0, 0)};
    dir_rows = {dir_rows, row(make_req(REQ_UNUSED, 24'sh7FFFFF), 1, ST_NOMATCH, 0, 0)};
    dir_rows = {dir_rows, row(make_req(REQ_QUERY, 24'sd1), 1, ST_MATCH, 2, 9)};
    dir_rows = {dir_rows, row(make_req(REQ_CLEAR, 24'sh123456), 1, ST_CLEARED, 0, 0)};
    dir_rows = {dir_rows, row(make_req(REQ_QUERY, 24'sd0), 1, ST_NOMATCH, 0, 0)};
    dir_rows = {dir_rows, row(make_req(REQ_LOAD, 24'sd5), 1, ST_LOADED, 0, 0)};
    dir_rows = {dir_rows, row(make_req(REQ_QUERY, 24'sd4), 1, ST_MATCH, 0, 9)};
    foreach (dir_rows[i]) send_row(dir_rows[i]);
    drain_answers();

    // Widest threshold: any pair of extremes now matches.
    write_threshold(THR_MAX);
    t = make_req(REQ_LOAD, 24'sh7FFFFF);
    send_request(t);
    t = make_req(REQ_QUERY, -24'sh800000);
    send_request(t);
    t = make_req(REQ_QUERY, '0);
    for (int k = 0; k < 9; k++) t.c[k] = (k % 2) ? 24'sh7FFFFF : -24'sh800000;
    send_request(t);
    drain_answers();

    // Zero threshold: only exact matches pass.
    write_threshold('0);
    t = make_req(REQ_QUERY, 24'sd5);
    send_request(t);
    t = make_req(REQ_QUERY, 24'sd6);
    send_request(t);
    drain_answers();

    // Random phases: each idle pattern, then long hold-off, with threshold changes.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 12; recv_idle_pct = 73; write_threshold(THR_RESET); end
        1: begin send_idle_pct = 73; recv_idle_pct = 12;
                 write_threshold(THR_W'($urandom_range(8000000, 1000))); end
        default: begin send_idle_pct = 0; recv_idle_pct = 0;
                       write_threshold(THR_W'({$urandom(), $urandom()})); end
      endcase
      phase_items = 40;
      for (int i = 0; i < phase_items; i++) begin
        if (ph == 2 && i == 10) recv_holdoff = 300;
        send_request(random_req());
      end
      // Sender pauses here until every answer has come back.
      drain_answers();
    end

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
